// ===== rtl/ebv_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler angle to basis
// vector block: Q30 sine coefficients, sign-magnitude products, output rounding.
// No dependencies.
package ebv_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;

  localparam int IN_BITS   = 16;
  localparam int OUT_BITS  = 16;
  localparam int QI        = 30;
  localparam int MAG_BITS  = QI + 1;
  localparam int SUM_BITS  = QI + 3;
  localparam int PROD_BITS = 2 * MAG_BITS;

  localparam logic [MAG_BITS-1:0] ONE_QI = MAG_BITS'(1) << QI;

  localparam int SIN_TERMS = 7;
  localparam logic [MAG_BITS-1:0] SIN_COEF [SIN_TERMS] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  localparam int LANE_STAGES  = SIN_TERMS + 1;
  localparam int MERGE_STAGES = 4;

  localparam int NUM_ANG   = 3;
  localparam int ANG_YAW   = 0;
  localparam int ANG_PITCH = 1;
  localparam int ANG_ROLL  = 2;

  localparam int NUM_OUT   = 9;
  localparam int OUT_FWD_X = 0;
  localparam int OUT_FWD_Y = 1;
  localparam int OUT_FWD_Z = 2;
  localparam int OUT_RGT_X = 3;
  localparam int OUT_RGT_Y = 4;
  localparam int OUT_RGT_Z = 5;
  localparam int OUT_UP_X  = 6;
  localparam int OUT_UP_Y  = 7;
  localparam int OUT_UP_Z  = 8;

  localparam int RND_SH = QI - FRAC_BITS;
  localparam logic [SUM_BITS:0] RND_ADD =
    (RND_SH > 0) ? ((SUM_BITS + 1)'(1) << (RND_SH - 1)) : '0;
  localparam logic [SUM_BITS:0] OUT_LIM = (SUM_BITS + 1)'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic                neg;
    logic [MAG_BITS-1:0] mag;
  } sm_t;

  function automatic logic [MAG_BITS-1:0] umulq(input logic [MAG_BITS-1:0] a,
                                                input logic [MAG_BITS-1:0] b);
    logic [PROD_BITS-1:0] p;
    p = PROD_BITS'(a) * PROD_BITS'(b) + (PROD_BITS'(1) << (QI - 1));
    return p[QI +: MAG_BITS];
  endfunction

  function automatic sm_t smul(input sm_t a, input sm_t b);
    sm_t r;
    r.neg = a.neg ^ b.neg;
    r.mag = umulq(a.mag, b.mag);
    return r;
  endfunction

  function automatic sm_t sneg(input sm_t a);
    sm_t r;
    r.neg = ~a.neg;
    r.mag = a.mag;
    return r;
  endfunction

  function automatic logic signed [SUM_BITS-1:0] to_signed(input sm_t a);
    logic signed [SUM_BITS-1:0] m;
    m = signed'(SUM_BITS'(a.mag));
    return a.neg ? -m : m;
  endfunction

  function automatic logic [OUT_BITS-1:0] finish(input logic signed [SUM_BITS-1:0] v);
    logic            neg;
    logic [SUM_BITS:0] m;
    logic [SUM_BITS:0] r;
    neg = v[SUM_BITS-1];
    m   = neg ? (SUM_BITS + 1)'(-v) & {1'b0, {SUM_BITS{1'b1}}}
              : (SUM_BITS + 1)'(v);
    m   = (m + RND_ADD) >> RND_SH;
    if (m > OUT_LIM) begin
      m = OUT_LIM;
    end
    r = neg ? -m : m;
    return r[OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/ebv_sine_lane.sv =====
// One quarter-turn sine lane: squares the Q30 phase, runs the odd Taylor
// polynomial by Horner's rule with one registered multiply per stage.
// Depends on ebv_pkg.
module ebv_sine_lane (
  input  logic                                 clk_i,
  input  logic [ebv_pkg::LANE_STAGES-1:0]      en_i,
  input  logic [ebv_pkg::MAG_BITS-1:0]         u_i,
  output logic [ebv_pkg::MAG_BITS-1:0]         sin_o
);

  localparam int LS = ebv_pkg::LANE_STAGES;
  localparam int MB = ebv_pkg::MAG_BITS;

  logic [MB-1:0] u_q  [1:LS-1];
  logic [MB-1:0] t2_q [1:LS-2];
  logic [MB-1:0] p_q  [2:LS-1];
  logic [MB-1:0] s_q;
  logic [MB-1:0] s_d;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q[1]  <= u_i;
      t2_q[1] <= ebv_pkg::umulq(u_i, u_i);
    end
  end

  for (genvar k = 2; k <= LS - 1; k++) begin : g_horner
    logic [MB-1:0] p_in;
    if (k == 2) begin : g_first
      assign p_in = ebv_pkg::SIN_COEF[LS-2];
    end else begin : g_next
      assign p_in = p_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k-1]) begin
        u_q[k] <= u_q[k-1];
        p_q[k] <= ebv_pkg::SIN_COEF[LS-1-k] - ebv_pkg::umulq(t2_q[k-1], p_in);
      end
    end

    if (k <= LS - 2) begin : g_t2
      always_ff @(posedge clk_i) begin
        if (en_i[k-1]) begin
          t2_q[k] <= t2_q[k-1];
        end
      end
    end
  end

  always_comb begin
    s_d = ebv_pkg::umulq(u_q[LS-1], p_q[LS-1]);
    if (s_d > ebv_pkg::ONE_QI) begin
      s_d = ebv_pkg::ONE_QI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LS-1]) begin
      s_q <= s_d;
    end
  end

  assign sin_o = s_q;

endmodule

// ===== rtl/ebv_merge.sv =====
// Merge stage: applies quadrant signs to the lane sines, forms the pair and
// triple products, sums each component and rounds it to the output format.
// Depends on ebv_pkg.
module ebv_merge (
  input  logic                                                   clk_i,
  input  logic [ebv_pkg::MERGE_STAGES-1:0]                       en_i,
  input  logic [ebv_pkg::NUM_ANG-1:0][ebv_pkg::MAG_BITS-1:0]     sa_i,
  input  logic [ebv_pkg::NUM_ANG-1:0][ebv_pkg::MAG_BITS-1:0]     sb_i,
  input  ebv_pkg::quad_e [ebv_pkg::NUM_ANG-1:0]                  quad_i,
  output logic [ebv_pkg::NUM_OUT-1:0][ebv_pkg::OUT_BITS-1:0]     comp_o
);

  ebv_pkg::sm_t s [ebv_pkg::NUM_ANG];
  ebv_pkg::sm_t c [ebv_pkg::NUM_ANG];

  ebv_pkg::sm_t spcy_q, spsy_q, cpcy_q, cpsy_q, srcp_q, crcp_q;
  ebv_pkg::sm_t crsy_q, crcy_q, srsy_q, srcy_q, nsp_q, sr_q, cr_q;

  ebv_pkg::sm_t srspcy_q, srspsy_q, crspcy_q, crspsy_q;
  ebv_pkg::sm_t cpcy2_q, cpsy2_q, nsp2_q, srcp2_q, crcp2_q;
  ebv_pkg::sm_t crsy2_q, crcy2_q, srsy2_q, srcy2_q;

  logic signed [ebv_pkg::SUM_BITS-1:0] v_q [ebv_pkg::NUM_OUT];
  logic [ebv_pkg::NUM_OUT-1:0][ebv_pkg::OUT_BITS-1:0] out_q;

  always_comb begin
    for (int i = 0; i < ebv_pkg::NUM_ANG; i++) begin
      case (quad_i[i])
        ebv_pkg::QUAD_0: begin
          s[i] = '{neg: 1'b0, mag: sa_i[i]};
          c[i] = '{neg: 1'b0, mag: sb_i[i]};
        end
        ebv_pkg::QUAD_1: begin
          s[i] = '{neg: 1'b0, mag: sb_i[i]};
          c[i] = '{neg: 1'b1, mag: sa_i[i]};
        end
        ebv_pkg::QUAD_2: begin
          s[i] = '{neg: 1'b1, mag: sa_i[i]};
          c[i] = '{neg: 1'b1, mag: sb_i[i]};
        end
        default: begin
          s[i] = '{neg: 1'b1, mag: sb_i[i]};
          c[i] = '{neg: 1'b0, mag: sa_i[i]};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      spcy_q <= ebv_pkg::smul(s[ebv_pkg::ANG_PITCH], c[ebv_pkg::ANG_YAW]);
      spsy_q <= ebv_pkg::smul(s[ebv_pkg::ANG_PITCH], s[ebv_pkg::ANG_YAW]);
      cpcy_q <= ebv_pkg::smul(c[ebv_pkg::ANG_PITCH], c[ebv_pkg::ANG_YAW]);
      cpsy_q <= ebv_pkg::smul(c[ebv_pkg::ANG_PITCH], s[ebv_pkg::ANG_YAW]);
      srcp_q <= ebv_pkg::smul(s[ebv_pkg::ANG_ROLL], c[ebv_pkg::ANG_PITCH]);
      crcp_q <= ebv_pkg::smul(c[ebv_pkg::ANG_ROLL], c[ebv_pkg::ANG_PITCH]);
      crsy_q <= ebv_pkg::smul(c[ebv_pkg::ANG_ROLL], s[ebv_pkg::ANG_YAW]);
      crcy_q <= ebv_pkg::smul(c[ebv_pkg::ANG_ROLL], c[ebv_pkg::ANG_YAW]);
      srsy_q <= ebv_pkg::smul(s[ebv_pkg::ANG_ROLL], s[ebv_pkg::ANG_YAW]);
      srcy_q <= ebv_pkg::smul(s[ebv_pkg::ANG_ROLL], c[ebv_pkg::ANG_YAW]);
      nsp_q  <= ebv_pkg::sneg(s[ebv_pkg::ANG_PITCH]);
      sr_q   <= s[ebv_pkg::ANG_ROLL];
      cr_q   <= c[ebv_pkg::ANG_ROLL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      srspcy_q <= ebv_pkg::smul(sr_q, spcy_q);
      srspsy_q <= ebv_pkg::smul(sr_q, spsy_q);
      crspcy_q <= ebv_pkg::smul(cr_q, spcy_q);
      crspsy_q <= ebv_pkg::smul(cr_q, spsy_q);
      cpcy2_q  <= cpcy_q;
      cpsy2_q  <= cpsy_q;
      nsp2_q   <= nsp_q;
      srcp2_q  <= srcp_q;
      crcp2_q  <= crcp_q;
      crsy2_q  <= crsy_q;
      crcy2_q  <= crcy_q;
      srsy2_q  <= srsy_q;
      srcy2_q  <= srcy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      v_q[ebv_pkg::OUT_FWD_X] <= ebv_pkg::to_signed(cpcy2_q);
      v_q[ebv_pkg::OUT_FWD_Y] <= ebv_pkg::to_signed(cpsy2_q);
      v_q[ebv_pkg::OUT_FWD_Z] <= ebv_pkg::to_signed(nsp2_q);
      v_q[ebv_pkg::OUT_RGT_X] <= ebv_pkg::to_signed(crsy2_q)
                                 - ebv_pkg::to_signed(srspcy_q);
      v_q[ebv_pkg::OUT_RGT_Y] <= -ebv_pkg::to_signed(srspsy_q)
                                 - ebv_pkg::to_signed(crcy2_q);
      v_q[ebv_pkg::OUT_RGT_Z] <= ebv_pkg::to_signed(ebv_pkg::sneg(srcp2_q));
      v_q[ebv_pkg::OUT_UP_X]  <= ebv_pkg::to_signed(crspcy_q)
                                 + ebv_pkg::to_signed(srsy2_q);
      v_q[ebv_pkg::OUT_UP_Y]  <= ebv_pkg::to_signed(crspsy_q)
                                 - ebv_pkg::to_signed(srcy2_q);
      v_q[ebv_pkg::OUT_UP_Z]  <= ebv_pkg::to_signed(crcp2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int i = 0; i < ebv_pkg::NUM_OUT; i++) begin
        out_q[i] <= ebv_pkg::finish(v_q[i]);
      end
    end
  end

  assign comp_o = out_q;

endmodule

// ===== rtl/euler_angles_to_basis_vectors.sv =====
// Euler angles to forward/right/up basis vectors, Q2.14 outputs.
// 13 register stages: the input phase register, the sine lanes and the merge.
// Throughput: one item per cycle while the output is not stalled, set by the fully pipelined sine lanes and merge.
// Bubbles collapse under output stall; the input keeps taking items while a slot is free.
// Reset clears the stage valid bits only; no clearing pass.
module euler_angles_to_basis_vectors (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ebv_pkg::IN_BITS-1:0]         yaw_angle_i,
  input  logic [ebv_pkg::IN_BITS-1:0]         pitch_angle_i,
  input  logic [ebv_pkg::IN_BITS-1:0]         roll_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ebv_pkg::OUT_BITS-1:0] forward_x_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] forward_y_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] forward_z_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] right_x_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] right_y_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] right_z_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] up_x_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] up_y_o,
  output logic signed [ebv_pkg::OUT_BITS-1:0] up_z_o
);

  localparam int LS   = ebv_pkg::LANE_STAGES;
  localparam int MS   = ebv_pkg::MERGE_STAGES;
  localparam int NSTG = 1 + LS + MS;
  localparam int NA   = ebv_pkg::NUM_ANG;
  localparam int MB   = ebv_pkg::MAG_BITS;
  localparam logic [31:0] ANG_MASK = (32'(1) << ebv_pkg::ANGLE_BITS) - 32'(1);

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] ready;

  logic [NA-1:0][ebv_pkg::IN_BITS-1:0] angle;
  logic [NA-1:0][MB-1:0] ua_d, ub_d;
  logic [NA-1:0][MB-1:0] ua_q, ub_q;
  logic [NA-1:0][MB-1:0] sa, sb;
  ebv_pkg::quad_e [NA-1:0] quad_d;
  ebv_pkg::quad_e [NA-1:0] quad_q [0:LS];
  logic [ebv_pkg::NUM_OUT-1:0][ebv_pkg::OUT_BITS-1:0] comp;

  // Stage k may load when some stage at or after it is empty, or the output drains.
  for (genvar k = 0; k < NSTG; k++) begin : g_ready
    assign ready[k] = ~(&valid_q[NSTG-1:k]) | ~out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (ready[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_stall_o  = ~ready[0];
  assign out_valid_o = valid_q[NSTG-1];

  assign angle[ebv_pkg::ANG_YAW]   = yaw_angle_i;
  assign angle[ebv_pkg::ANG_PITCH] = pitch_angle_i;
  assign angle[ebv_pkg::ANG_ROLL]  = roll_angle_i;

  always_comb begin
    logic [31:0] phase;
    for (int i = 0; i < NA; i++) begin
      phase     = (32'(angle[i]) & ANG_MASK) << (32 - ebv_pkg::ANGLE_BITS);
      quad_d[i] = ebv_pkg::quad_e'(phase[31:30]);
      ua_d[i]   = {1'b0, phase[29:0]};
      ub_d[i]   = ebv_pkg::ONE_QI - {1'b0, phase[29:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      ua_q      <= ua_d;
      ub_q      <= ub_d;
      quad_q[0] <= quad_d;
    end
  end

  for (genvar j = 1; j <= LS; j++) begin : g_quad
    always_ff @(posedge clk_i) begin
      if (ready[j]) begin
        quad_q[j] <= quad_q[j-1];
      end
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_lane
    ebv_sine_lane u_lane_a (
      .clk_i (clk_i),
      .en_i  (ready[LS:1]),
      .u_i   (ua_q[i]),
      .sin_o (sa[i])
    );

    ebv_sine_lane u_lane_b (
      .clk_i (clk_i),
      .en_i  (ready[LS:1]),
      .u_i   (ub_q[i]),
      .sin_o (sb[i])
    );
  end

  ebv_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (ready[NSTG-1:LS+1]),
    .sa_i   (sa),
    .sb_i   (sb),
    .quad_i (quad_q[LS]),
    .comp_o (comp)
  );

  assign forward_x_o = signed'(comp[ebv_pkg::OUT_FWD_X]);
  assign forward_y_o = signed'(comp[ebv_pkg::OUT_FWD_Y]);
  assign forward_z_o = signed'(comp[ebv_pkg::OUT_FWD_Z]);
  assign right_x_o   = signed'(comp[ebv_pkg::OUT_RGT_X]);
  assign right_y_o   = signed'(comp[ebv_pkg::OUT_RGT_Y]);
  assign right_z_o   = signed'(comp[ebv_pkg::OUT_RGT_Z]);
  assign up_x_o      = signed'(comp[ebv_pkg::OUT_UP_X]);
  assign up_y_o      = signed'(comp[ebv_pkg::OUT_UP_Y]);
  assign up_z_o      = signed'(comp[ebv_pkg::OUT_UP_Z]);

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for euler_angles_to_basis_vectors: random handshake gaps on both
// sides, fixed-point prediction of the nine basis components for each accepted item.
// Depends on ebv_pkg and the block under test.
module tb_top;
  import ebv_pkg::*;

  typedef logic [NUM_OUT-1:0][OUT_BITS-1:0] basis_t;

  localparam bit [63:0] Q_ONE          = 64'd1 << 30;
  localparam int        WATCHDOG_LIMIT = 4000;
  localparam int        TAIL_CYCLES    = 20;

  localparam bit [63:0] SINE_TAYLOR [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
    64'd172272, 64'd3864, 64'd61
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [IN_BITS-1:0]  yaw_angle_i   = '0;
  logic [IN_BITS-1:0]  pitch_angle_i = '0;
  logic [IN_BITS-1:0]  roll_angle_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic signed [OUT_BITS-1:0] forward_x_o, forward_y_o, forward_z_o;
  logic signed [OUT_BITS-1:0] right_x_o, right_y_o, right_z_o;
  logic signed [OUT_BITS-1:0] up_x_o, up_y_o, up_z_o;

  basis_t pending_basis [$];
  int     mismatch_count = 0;
  int     idle_cycles    = 0;
  bit     quiet          = 1'b0;
  string  comp_name [NUM_OUT] = '{
    "forward_x", "forward_y", "forward_z", "right_x", "right_y", "right_z",
    "up_x", "up_y", "up_z"
  };

  euler_angles_to_basis_vectors i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .yaw_angle_i   (yaw_angle_i),
    .pitch_angle_i (pitch_angle_i),
    .roll_angle_i  (roll_angle_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .forward_x_o   (forward_x_o),
    .forward_y_o   (forward_y_o),
    .forward_z_o   (forward_z_o),
    .right_x_o     (right_x_o),
    .right_y_o     (right_y_o),
    .right_z_o     (right_z_o),
    .up_x_o        (up_x_o),
    .up_y_o        (up_y_o),
    .up_z_o        (up_z_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit [63:0] qmul(input bit [63:0] a, input bit [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic bit [63:0] quarter_wave(input bit [63:0] u);
    bit [63:0] t2;
    bit [63:0] p;
    int        k;
    t2 = qmul(u, u);
    p  = SINE_TAYLOR[6];
    for (k = 5; k >= 0; k--) begin
      p = SINE_TAYLOR[k] - qmul(t2, p);
    end
    p = qmul(u, p);
    return (p > Q_ONE) ? Q_ONE : p;
  endfunction

  function automatic void angle_sin_cos(input logic [IN_BITS-1:0] ang,
                                        output longint s, output longint c);
    bit [63:0] phase;
    bit [63:0] x;
    longint    sa;
    longint    sb;
    quad_e     q;
    phase = (64'(ang) << (32 - ANGLE_BITS)) & 64'hFFFF_FFFF;
    q     = quad_e'(phase[31:30]);
    x     = phase & (Q_ONE - 64'd1);
    sa    = longint'(quarter_wave(x));
    sb    = longint'(quarter_wave(Q_ONE - x));
    case (q)
      QUAD_0: begin
        s = sa;  c = sb;
      end
      QUAD_1: begin
        s = sb;  c = -sa;
      end
      QUAD_2: begin
        s = -sa; c = -sb;
      end
      default: begin
        s = -sb; c = sa;
      end
    endcase
  endfunction

  function automatic bit [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Round magnitudes so products are symmetric about zero.
  function automatic longint sprod(input longint a, input longint b);
    bit [63:0] m;
    m = qmul(abs64(a), abs64(b));
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [OUT_BITS-1:0] round_q14(input longint v);
    bit [63:0] m;
    longint    r;
    m = abs64(v);
    m = (m + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (m > (64'd1 << FRAC_BITS)) begin
      m = 64'd1 << FRAC_BITS;
    end
    r = (v < 0) ? -longint'(m) : longint'(m);
    return r[OUT_BITS-1:0];
  endfunction

  function automatic basis_t basis_from_angles(input logic [IN_BITS-1:0] yaw,
                                               input logic [IN_BITS-1:0] pitch,
                                               input logic [IN_BITS-1:0] roll);
    longint sy, cy, sp, cp, sr, cr, spcy, spsy;
    basis_t b;
    angle_sin_cos(yaw, sy, cy);
    angle_sin_cos(pitch, sp, cp);
    angle_sin_cos(roll, sr, cr);
    spcy = sprod(sp, cy);
    spsy = sprod(sp, sy);
    b[OUT_FWD_X] = round_q14(sprod(cp, cy));
    b[OUT_FWD_Y] = round_q14(sprod(cp, sy));
    b[OUT_FWD_Z] = round_q14(-sp);
    b[OUT_RGT_X] = round_q14(-sprod(sr, spcy) + sprod(cr, sy));
    b[OUT_RGT_Y] = round_q14(-sprod(sr, spsy) - sprod(cr, cy));
    b[OUT_RGT_Z] = round_q14(-sprod(sr, cp));
    b[OUT_UP_X]  = round_q14(sprod(cr, spcy) + sprod(sr, sy));
    b[OUT_UP_Y]  = round_q14(sprod(cr, spsy) - sprod(sr, cy));
    b[OUT_UP_Z]  = round_q14(sprod(cr, cp));
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_BITS-1:0] edge_angle();
    logic [IN_BITS-1:0] base;
    base = IN_BITS'($urandom_range(0, 3)) << 14;
    return base + IN_BITS'($urandom_range(0, 8)) - IN_BITS'(4);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_angles(input logic [IN_BITS-1:0] yaw,
                             input logic [IN_BITS-1:0] pitch,
                             input logic [IN_BITS-1:0] roll);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i    <= 1'b0;
      yaw_angle_i   <= IN_BITS'($urandom);
      pitch_angle_i <= IN_BITS'($urandom);
      roll_angle_i  <= IN_BITS'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    yaw_angle_i   <= yaw;
    pitch_angle_i <= pitch;
    roll_angle_i  <= roll;
    do @(posedge clk_i); while (in_stall_o);
    pending_basis.push_back(basis_from_angles(yaw, pitch, roll));
  endtask

  task automatic settle_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_basis.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_angles();
    send_angles(16'h0000, 16'h0000, 16'h0000);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h4000, 16'h0000, 16'h0000);
    send_angles(16'h8000, 16'h0000, 16'h0000);
    send_angles(16'hC000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h4000, 16'h0000);
    send_angles(16'h0000, 16'h8000, 16'h0000);
    send_angles(16'h0000, 16'hC000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h4000);
    send_angles(16'h0000, 16'h0000, 16'h8000);
    send_angles(16'h0000, 16'h0000, 16'hC000);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'hE000, 16'h6000, 16'hA000);
    send_angles(16'h0001, 16'h0001, 16'h0001);
    send_angles(16'h3FFF, 16'h4001, 16'hBFFF);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    send_angles(16'h7FFF, 16'h8001, 16'hFFFF);
    send_angles(16'h2000, 16'h4000, 16'h6000);
    send_angles(16'h6000, 16'hC000, 16'h2000);
  endtask

  task automatic test_quadrant_edges();
    repeat (100) begin
      send_angles(edge_angle(), edge_angle(), edge_angle());
    end
  endtask

  task automatic test_random_angles();
    int n;
    for (n = 0; n < 500; n++) begin
      if (n == 250) begin
        settle_pipeline();
      end
      send_angles(IN_BITS'($urandom), IN_BITS'($urandom), IN_BITS'($urandom));
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (100) begin
      send_angles(IN_BITS'($urandom), IN_BITS'($urandom), IN_BITS'($urandom));
    end
    quiet = 1'b0;
  endtask

  initial begin : stall_gen
    bit stalling;
    int run;
    stalling = 1'b0;
    run      = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        stalling = !stalling && !quiet;
        run      = stalling ? pick_gap() : $urandom_range(1, 40);
        if (stalling && run == 0) begin
          run = 1;
        end
      end
      run--;
      out_stall_i <= stalling;
    end
  end

  always @(posedge clk_i) begin : check_results
    basis_t got;
    basis_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got[OUT_FWD_X] = forward_x_o;
      got[OUT_FWD_Y] = forward_y_o;
      got[OUT_FWD_Z] = forward_z_o;
      got[OUT_RGT_X] = right_x_o;
      got[OUT_RGT_Y] = right_y_o;
      got[OUT_RGT_Z] = right_z_o;
      got[OUT_UP_X]  = up_x_o;
      got[OUT_UP_Y]  = up_y_o;
      got[OUT_UP_Z]  = up_z_o;
      if (pending_basis.size() == 0) begin
        flag_mismatch("result with no item pending");
      end else begin
        want = pending_basis.pop_front();
        for (int i = 0; i < NUM_OUT; i++) begin
          if (got[i] !== want[i]) begin
            flag_mismatch($sformatf("%s got %h want %h", comp_name[i], got[i], want[i]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_angles();
    test_quadrant_edges();
    test_random_angles();
    test_back_to_back();
    settle_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_basis.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ebv_pkg.sv
rtl/ebv_sine_lane.sv
rtl/ebv_merge.sv
rtl/euler_angles_to_basis_vectors.sv
test/tb_top.sv
